// File: src/mfbp_pkg.sv
// Shared types for the MSB-first bit field packer.
package mfbp_pkg;

    typedef enum logic [1:0] {
        OP_PACK  = 2'd0,
        OP_SKIP  = 2'd1,
        OP_FLUSH = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam int unsigned ValueW  = 32;
    localparam int unsigned CountW  = 6;
    localparam int unsigned OffsetW = 32;
    localparam int unsigned LenW    = 30;
    localparam int unsigned ByteBufW = 64;

    typedef struct packed {
        op_t               opcode;
        logic [CountW-1:0] bit_count;
        logic [ValueW-1:0] field_value;
    } item_t;

    typedef struct packed {
        logic [6:0]         partial;
        logic [2:0]         pending;
        logic [OffsetW-1:0] offset;
    } pstate_t;

    typedef struct packed {
        logic [ByteBufW-1:0] bytes;
        logic [3:0]          nbytes;
        logic                status;
        logic [LenW-1:0]     msg_bytes;
    } plan_t;

endpackage

// File: src/msb_first_bit_field_packer.sv
// Top level of the MSB-first bit field packer: input register, packer state, result stage.
// Path: an accepted item is held in the input register; its plan is then loaded into the
//   result stage, whose register offers the item's first result.
// Throughput: one item per cycle for items with one result while m_tready is high; the
//   result stage sends one byte per cycle (up to eight per item) before taking the next.
// Reset: synchronous active-low aresetn empties both stages and clears the partial byte,
//   its bit count and the message bit offset.
module msb_first_bit_field_packer import mfbp_pkg::*; #(
    parameter int unsigned MAX_FIELD_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // bit_count[5:0], field_value[37:6], zeros[39:38]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // byte_out[7:0], message_bytes[37:8], zeros[39:38]
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // byte_valid[0], status[1]
);

    item_t   item_reg, item_next;
    logic    in_valid_reg, in_valid_next;
    pstate_t state_reg, state_next;
    pstate_t state_calc;
    plan_t   plan;
    logic    emit_ready;
    logic    xfer;

    mfbp_plan #(
        .MAX_FIELD_BITS (MAX_FIELD_BITS)
    ) u_plan (
        .item       (item_reg),
        .state      (state_reg),
        .plan       (plan),
        .state_next (state_calc)
    );

    mfbp_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (in_valid_reg),
        .load_ready (emit_ready),
        .load_plan  (plan),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    always_comb begin
        xfer          = in_valid_reg && emit_ready;
        s_tready      = !in_valid_reg || emit_ready;
        item_next     = item_reg;
        in_valid_next = in_valid_reg;
        state_next    = state_reg;
        if (xfer) begin
            in_valid_next = 1'b0;
            state_next    = state_calc;
        end
        if (s_tvalid && s_tready) begin
            item_next.opcode      = op_t'(s_tuser);
            item_next.bit_count   = s_tdata[5:0];
            item_next.field_value = s_tdata[37:6];
            in_valid_next         = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (xfer && item_reg.opcode == OP_FLUSH) |=>
            (state_reg.pending == 3'd0 && state_reg.offset == '0))
        else $error("flush left packer state");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.partial >> state_reg.pending) == 7'd0)
        else $error("partial byte holds bits beyond its count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> m_tlast)
        else $error("empty result not marked last");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tuser[1] == 1'b0 && m_tdata[37:8] == '0))
        else $error("status or length on a result before the last");

endmodule

// File: src/mfbp_plan.sv
// Combinational bit alignment: builds the bytes of one item and the next packer state.
module mfbp_plan import mfbp_pkg::*; #(
    parameter int unsigned MAX_FIELD_BITS = 32
) (
    input  item_t   item,
    input  pstate_t state,
    output plan_t   plan,
    output pstate_t state_next
);

    localparam logic [CountW-1:0] MaxBits = CountW'(MAX_FIELD_BITS);

    logic              err;
    logic [CountW-1:0] count_eff;
    logic [ValueW-1:0] val_bits;
    logic [6:0]        total;
    logic [71:0]       aligned;
    logic [6:0]        low_bits;
    logic [32:0]       len_sum;
    logic [OffsetW-1:0] offset_sum;

    always_comb begin
        err       = (item.opcode == OP_PACK) && (item.bit_count > MaxBits);
        count_eff = '0;
        val_bits  = '0;
        case (item.opcode)
            OP_PACK: begin
                if (!err) begin
                    count_eff = item.bit_count;
                    val_bits  = item.field_value & ~({ValueW{1'b1}} << item.bit_count);
                end
            end
            OP_SKIP: begin
                count_eff = item.bit_count;
            end
            default: begin
                count_eff = '0;
            end
        endcase

        total   = {4'd0, state.pending} + {1'b0, count_eff};
        aligned = ({65'd0, state.partial} << (7'd72 - {4'd0, state.pending}))
                | ({40'd0, val_bits} << (7'd72 - total));
        low_bits = (7'(state.partial << count_eff) | val_bits[6:0])
                 & ~(7'h7f << total[2:0]);

        offset_sum = state.offset + {26'd0, count_eff};
        len_sum    = {1'b0, offset_sum} + 33'd7;

        plan.bytes     = aligned[71:8];
        plan.status    = err;
        plan.msg_bytes = len_sum[32:3];
        plan.nbytes    = total[6:3];

        state_next.partial = low_bits;
        state_next.pending = total[2:0];
        state_next.offset  = offset_sum;

        if (item.opcode == OP_FLUSH) begin
            plan.nbytes = (state.pending != 3'd0) ? 4'd1 : 4'd0;
            state_next  = '0;
        end
    end

endmodule

// File: src/mfbp_emit.sv
// Result stage: holds one planned item and sends its bytes one per cycle while m_tready is high.
module mfbp_emit import mfbp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load_valid,
    output logic        load_ready,
    input  plan_t       load_plan,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // byte_out[7:0], message_bytes[37:8], zeros[39:38]
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // byte_valid[0], status[1]
);

    plan_t      plan_reg, plan_next;
    logic       valid_reg, valid_next;
    logic [2:0] idx_reg, idx_next;
    logic       byte_valid;
    logic       last;
    logic [7:0] byte_sel;

    always_comb begin
        byte_valid = plan_reg.nbytes != 4'd0;
        last       = !byte_valid || ({1'b0, idx_reg} == plan_reg.nbytes - 4'd1);
        byte_sel   = plan_reg.bytes[{3'd7 - idx_reg, 3'b000} +: 8];
        load_ready = !valid_reg || (m_tready && last);
    end

    always_comb begin
        m_tvalid = valid_reg;
        m_tlast  = last;
        m_tuser  = {last & plan_reg.status, byte_valid};
        m_tdata  = {2'b00, last ? plan_reg.msg_bytes : {LenW{1'b0}},
                    byte_valid ? byte_sel : 8'd0};
    end

    always_comb begin
        plan_next  = plan_reg;
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load_valid && load_ready) begin
            plan_next  = load_plan;
            valid_next = 1'b1;
            idx_next   = '0;
        end else if (valid_reg && m_tready) begin
            if (last) begin
                valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        plan_reg <= plan_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

endmodule
